// ----- rtl/core/booth_signed_multiplier_defines.svh -----
// Assertion macros shared by the booth_signed_multiplier checker.
`ifndef BOOTH_SIGNED_MULTIPLIER_DEFINES_SVH
`define BOOTH_SIGNED_MULTIPLIER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BSM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define BSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bsm_pkg.sv -----
// Package for the Booth multiplier: widths, controller states and control structs.
package bsm_pkg;

  localparam int unsigned OPERAND_BITS      = 8;
  localparam int unsigned PRODUCT_BITS      = 16;
  localparam int unsigned CFG_BITS          = 4;
  localparam int unsigned DEFAULT_MAX_WIDTH = 8;
  localparam logic [CFG_BITS-1:0] WIDTH_RESET = 4'd8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } bsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } bsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
  } bsm_status_t;

endpackage

// ----- rtl/core/bsm_datapath.sv -----
// Booth datapath: operand load, add/subtract and shift step, step counter, product register.
module bsm_datapath #(
  parameter int unsigned MAX_WIDTH = bsm_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic        [bsm_pkg::CFG_BITS-1:0]     operand_width,
  input  logic signed [bsm_pkg::OPERAND_BITS-1:0] multiplicand,
  input  logic signed [bsm_pkg::OPERAND_BITS-1:0] multiplier,
  input  bsm_pkg::bsm_cmd_t                       cmd,
  output bsm_pkg::bsm_status_t                    status,
  output logic signed [bsm_pkg::PRODUCT_BITS-1:0] product
);
  import bsm_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = MAX_WIDTH + 2;          // accumulator, sign-extended above eff_w
  localparam int unsigned PW = AW + MAX_WIDTH;         // accumulator : multiplier
  localparam int unsigned EW = (AW > OPERAND_BITS) ? AW : OPERAND_BITS;
  localparam int unsigned IW = $clog2(EW);
  localparam int unsigned XW = (PW > PRODUCT_BITS) ? PW : PRODUCT_BITS;
  localparam int unsigned SW = $clog2(MAX_WIDTH);

  localparam logic [1:0] PAIR_SUB = 2'b10;
  localparam logic [1:0] PAIR_ADD = 2'b01;

  logic        [WW-1:0] eff_w;
  logic        [IW-1:0] sign_sel;
  logic signed [EW-1:0] mc_ext;
  logic signed [EW-1:0] mp_ext;
  logic                 mc_sign;
  logic        [AW-1:0] m_load;

  logic        [AW-1:0] m;
  logic        [PW-1:0] p;
  logic                 qm1;
  logic        [WW-1:0] cnt;

  logic        [AW-1:0] a_cur;
  logic        [AW-1:0] a_sum;
  logic        [AW-1:0] a_wrap;
  logic        [PW-1:0] p_next;
  logic        [SW-1:0] shamt;
  logic signed [XW-1:0] p_ext;
  logic signed [XW-1:0] p_adj;

  // Clamp the width register to 1..MAX_WIDTH
  always_comb begin
    if (operand_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(operand_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(operand_width);
    end
  end

  // Multiplicand: keep the low eff_w bits, sign-extended from bit eff_w-1
  assign mc_ext   = EW'(multiplicand);
  assign mp_ext   = EW'(multiplier);
  assign sign_sel = IW'(eff_w - WW'(1));
  assign mc_sign  = mc_ext[sign_sel];

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      m_load[i] = (32'(eff_w) > i) ? mc_ext[i] : mc_sign;
    end
  end

  // One Booth step
  assign a_cur = p[PW-1 -: AW];

  always_comb begin
    case ({p[0], qm1})
      PAIR_SUB: a_sum = a_cur - m;
      PAIR_ADD: a_sum = a_cur + m;
      default:  a_sum = a_cur;
    endcase
  end

  // Accumulator wraps at eff_w bits; the shift takes its sign from bit eff_w-1
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      a_wrap[i] = (32'(eff_w) > i) ? a_sum[i] : a_sum[sign_sel];
    end
  end

  assign p_next = {a_wrap[AW-1], a_wrap, p[MAX_WIDTH-1:1]};

  // Multiplier bits above eff_w end up below the product and are shifted out
  assign shamt = SW'(MAX_WIDTH - 32'(eff_w));
  assign p_ext = XW'($signed(p_next));
  assign p_adj = p_ext >>> shamt;

  assign status.last = (cnt == WW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= eff_w;
    end else if (cmd.step) begin
      cnt <= cnt - WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m   <= m_load;
      p   <= {AW'(0), mp_ext[MAX_WIDTH-1:0]};
      qm1 <= 1'b0;
    end else if (cmd.step) begin
      p   <= p_next;
      qm1 <= p[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && status.last) begin
      product <= p_adj[PRODUCT_BITS-1:0];
    end
  end

endmodule

// ----- rtl/core/bsm_controller.sv -----
// Booth controller: idle/run state machine and the done strobe.
module bsm_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bsm_pkg::bsm_status_t status,
  output bsm_pkg::bsm_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import bsm_pkg::*;

  bsm_state_t state;
  bsm_state_t state_next;
  logic       done_next;

  always_comb begin
    case (state)
      ST_IDLE: state_next = start ? ST_RUN : ST_IDLE;
      ST_RUN:  state_next = status.last ? ST_IDLE : ST_RUN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: begin
        cmd.load  = start;
        cmd.step  = 1'b0;
        busy      = 1'b0;
        done_next = 1'b0;
      end
      ST_RUN: begin
        cmd.load  = 1'b0;
        cmd.step  = 1'b1;
        busy      = 1'b1;
        done_next = status.last;
      end
      default: begin
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        busy      = 1'b0;
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// ----- rtl/core/booth_signed_multiplier.sv -----
// Top level of the radix-2 Booth signed multiplier.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------------------
//   input    | start, busy              | multiplicand[7:0], multiplier[7:0]
//   result   | done (one-cycle strobe)  | product[15:0]
//   config   | cfg_valid, cfg_ready     | cfg_data[3:0] (operand_width)
//
// An item runs one add/subtract-and-shift step per operand bit, W =
// operand_width clamped to 1..MAX_WIDTH, through a single adder; the product
// appears with done in the cycle after the last step, and start is taken
// again in that same cycle.
// Reset is synchronous; it returns to idle and sets operand_width to 8.
// The receiver cannot stall; cfg_ready is always high.
module booth_signed_multiplier #(
  parameter int unsigned MAX_WIDTH = bsm_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [bsm_pkg::OPERAND_BITS-1:0] multiplicand,
  input  logic signed [bsm_pkg::OPERAND_BITS-1:0] multiplier,
  output logic                                    done,
  output logic signed [bsm_pkg::PRODUCT_BITS-1:0] product,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [bsm_pkg::CFG_BITS-1:0]     cfg_data
);
  import bsm_pkg::*;

  logic [CFG_BITS-1:0] operand_width;
  bsm_cmd_t            cmd;
  bsm_status_t         status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_width <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      operand_width <= cfg_data;
    end
  end

  bsm_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bsm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .operand_width (operand_width),
    .multiplicand  (multiplicand),
    .multiplier    (multiplier),
    .cmd           (cmd),
    .status        (status),
    .product       (product)
  );

endmodule

// ----- rtl/core/bsm_checker.sv -----
// Port-level checker for the Booth multiplier, bound to the top level.
`include "booth_signed_multiplier_defines.svh"

module bsm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted item always runs at least one step
  `BSM_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted item did not start")

  // The result strobe only shows once the block is free again
  `BSM_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "done while busy")

  // The strobe lasts one cycle
  `BSM_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held past one cycle")

  // Every item that finishes delivers its result
  `BSM_ASSERT_NOW(a_finish_done, clk, rst, $fell(busy) && !$past(rst), done,
                  "item finished without done")

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
